/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the following edge
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/acpis5_pkg.sv */
// ----------------------------------------------------------------------------
// acpis5_pkg
// Shared types, constants and the package decoder for the S5 sleep-type finder.
// ----------------------------------------------------------------------------
package acpis5_pkg;

    // Byte history: current beat plus the fifteen before it
    localparam int WINDOW_BYTES = 16;
    localparam int CAND_SPAN    = WINDOW_BYTES - 1;
    localparam int HIST_DEPTH   = WINDOW_BYTES - 1;
    localparam int MIN_OFS      = 4;
    localparam int QUEUE_DEPTH  = 2;

    // AML codes
    localparam logic [7:0] NAME_US     = 8'h5F;
    localparam logic [7:0] NAME_S      = 8'h53;
    localparam logic [7:0] NAME_5      = 8'h35;
    localparam logic [7:0] NAME_PREFIX = 8'h08;
    localparam logic [7:0] PKG_OP      = 8'h12;
    localparam logic [7:0] BYTE_PREFIX = 8'h0A;
    localparam logic [7:0] LEN_MASK    = 8'hC0;

    typedef logic [CAND_SPAN-1:0][7:0] span_t;
    typedef logic [3:0]                span_idx_t;
    typedef logic [3:0]                fill_t;

    typedef struct packed {
        logic       found;
        logic [7:0] sleep_type_a;
        logic [7:0] sleep_type_b;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t res;
    } push_t;

    // Decode one candidate span; c[0] is the first name byte, n bytes are valid
    function automatic result_t try_span(input span_t c, input span_idx_t n);
        result_t   r;
        span_idx_t p;
        logic      ok;
        logic [1:0] ext;
        begin
            r   = '0;
            ext = 2'((c[5] & LEN_MASK) >> 6);
            ok  = (c[0] == NAME_US) && (c[1] == NAME_S) && (c[2] == NAME_5) &&
                  (c[3] == NAME_US) && (c[4] == PKG_OP);
            // skip package length bytes and the element count
            p  = span_idx_t'(4'd7 + {2'b00, ext});
            ok = ok && (p < n);
            if (c[p] == BYTE_PREFIX)
            begin
                p = p + 4'd1;
            end
            ok = ok && (p < n);
            r.sleep_type_a = c[p];
            p  = p + 4'd1;
            ok = ok && (p < n);
            if (c[p] == BYTE_PREFIX)
            begin
                p = p + 4'd1;
            end
            ok = ok && (p < n);
            r.sleep_type_b = c[p];
            r.found = ok;
            if (!ok)
            begin
                r = '0;
            end
            return r;
        end
    endfunction

endpackage

/* rtl/acpi_s5_sleep_type_finder_unit.sv */
// ----------------------------------------------------------------------------
// acpi_s5_sleep_type_finder_unit
// Scans one table's AML body per run and reports the S5 sleep-type bytes.
// ----------------------------------------------------------------------------
// Input channel: one AML byte per beat (aml_byte), last_byte marks the final
// byte of a table. Output channel: one beat per table with found and the two
// raw sleep-type bytes (zero when nothing was found); shift them left by 10
// before writing the sleep control register.
// Throughput: one input byte per cycle while in_stall is low. Each "_S5_"
// candidate is decoded once the fifteen bytes starting at its name have
// arrived; the rest are decoded together on the last byte.
// Latency: the result beat is visible the cycle after the fifteenth byte of
// the matching candidate, or after the last byte if that comes first or no
// package matched. Earlier results still queued delay it further.
// Bytes after a match are consumed without output until the table ends.
// A two-entry result queue separates the sides: in_stall rises only when
// two results wait because out_stall held the output back.
// Reset clears the history count, the match flag and the queue; the block
// then waits for the first byte of a new table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acpi_s5_sleep_type_finder_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  aml_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        found,
    output logic [7:0]  sleep_type_a,
    output logic [7:0]  sleep_type_b
);

    acpis5_pkg::push_t push;
    logic              accept;
    logic              sleep_any;

    assign accept    = in_valid && !in_stall;
    assign sleep_any = |{sleep_type_a, sleep_type_b};

    // Front: byte history and candidate decode
    acpis5_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .aml_byte  (aml_byte),
        .last_byte (last_byte),
        .push      (push)
    );

    // Back: result queue and output channel
    acpis5_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (in_stall),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .sleep_type_a (sleep_type_a),
        .sleep_type_b (sleep_type_b)
    );

    // Checks
    `ASSERT_IMP(a_no_push_when_full, push.valid, !in_stall, "result pushed into full queue")
    `ASSERT_NXT(a_push_shows, push.valid, out_valid, "pushed result not presented")
    `ASSERT_IMP(a_full_has_output, in_stall, out_valid, "input stalled with no output pending")
    `ASSERT_IMP(a_miss_is_zero, out_valid && !found, !sleep_any, "miss beat carries data")

endmodule

/* rtl/acpis5_front.sv */
// ----------------------------------------------------------------------------
// acpis5_front
// Accepts AML beats, keeps the byte history and tests "_S5_" candidates.
// ----------------------------------------------------------------------------
module acpis5_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          aml_byte,
    input  logic                last_byte,
    output acpis5_pkg::push_t   push
);

    logic [acpis5_pkg::HIST_DEPTH-1:0][7:0]   hist_reg;
    logic [acpis5_pkg::HIST_DEPTH-1:0][7:0]   hist_next;
    acpis5_pkg::fill_t                        cnt_reg;
    acpis5_pkg::fill_t                        cnt_next;
    logic                                     done_reg;
    logic                                     done_next;
    logic [acpis5_pkg::WINDOW_BYTES-1:0][7:0] win;
    logic [acpis5_pkg::CAND_SPAN-1:acpis5_pkg::MIN_OFS] hit_vec;
    acpis5_pkg::result_t cand [acpis5_pkg::CAND_SPAN-1:acpis5_pkg::MIN_OFS];
    acpis5_pkg::result_t sel;
    logic                hit_any;

    // Newest byte at index 0
    assign win = {hist_reg, aml_byte};

    // Test every candidate offset in parallel; offset d starts d bytes back
    for (genvar d = acpis5_pkg::MIN_OFS; d < acpis5_pkg::CAND_SPAN; d++)
    begin : g_cand
        acpis5_pkg::span_t span;
        logic              prefix_ok;
        logic              exists;
        logic              tested;

        always_comb
        begin
            span = '0;
            for (int i = 0; i <= d; i++)
            begin
                span[i] = win[d-i];
            end
        end

        assign cand[d]    = acpis5_pkg::try_span(span, acpis5_pkg::span_idx_t'(d + 1));
        assign exists     = (4'(d) <= cnt_reg);
        assign prefix_ok  = (cnt_reg == 4'(d)) || (win[d+1] == acpis5_pkg::NAME_PREFIX);
        assign tested     = (d == acpis5_pkg::CAND_SPAN - 1) || last_byte;
        assign hit_vec[d] = cand[d].found && prefix_ok && exists && tested;
    end

    // Pick the earliest candidate in table order (largest offset)
    always_comb
    begin
        sel = '0;
        for (int d = acpis5_pkg::MIN_OFS; d < acpis5_pkg::CAND_SPAN; d++)
        begin
            if (hit_vec[d])
            begin
                sel = cand[d];
            end
        end
    end

    assign hit_any = |hit_vec;

    // Emit a beat on a match or at table end, unless this table already matched
    always_comb
    begin
        push.valid = accept && !done_reg && (hit_any || last_byte);
        push.res   = sel;
    end

    // Advance history, fill count and match flag
    always_comb
    begin
        hist_next = hist_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (accept)
        begin
            hist_next = {hist_reg[acpis5_pkg::HIST_DEPTH-2:0], aml_byte};
            if (last_byte)
            begin
                cnt_next  = '0;
                done_next = 1'b0;
            end
            else if (!done_reg)
            begin
                done_next = hit_any;
                if (cnt_reg != '1)
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hist_reg <= hist_next;
    end

endmodule

/* rtl/acpis5_back.sv */
// ----------------------------------------------------------------------------
// acpis5_back
// Two-entry result queue whose head drives the output channel.
// ----------------------------------------------------------------------------
module acpis5_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  acpis5_pkg::push_t   push,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                found,
    output logic [7:0]          sleep_type_a,
    output logic [7:0]          sleep_type_b
);

    acpis5_pkg::result_t mem_reg [acpis5_pkg::QUEUE_DEPTH];
    logic                wr_ptr_reg;
    logic                wr_ptr_next;
    logic                rd_ptr_reg;
    logic                rd_ptr_next;
    logic [1:0]          cnt_reg;
    logic [1:0]          cnt_next;
    logic                pop;

    assign full      = (cnt_reg == 2'(acpis5_pkg::QUEUE_DEPTH));
    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && !out_stall;

    // Drive the head entry
    assign found        = mem_reg[rd_ptr_reg].found;
    assign sleep_type_a = mem_reg[rd_ptr_reg].sleep_type_a;
    assign sleep_type_b = mem_reg[rd_ptr_reg].sleep_type_b;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push.valid;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg;
        if (push.valid && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push.valid)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the incoming result beat
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            mem_reg[wr_ptr_reg] <= push.res;
        end
    end

endmodule
